/* sv/tmg_pkg.sv */
// Shared constants, types and arithmetic helpers for the transform matrix generator.
package tmg_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;

    localparam int AW = 34;   // angle and CORDIC datapath width
    localparam int PW = 68;   // product width

    localparam logic [2:0] CMD_TRANSLATE = 3'd0;
    localparam logic [2:0] CMD_SCALE     = 3'd1;
    localparam logic [2:0] CMD_AXIS_ROT  = 3'd2;
    localparam logic [2:0] CMD_ROT_X     = 3'd3;
    localparam logic [2:0] CMD_ROT_Y     = 3'd4;
    localparam logic [2:0] CMD_ROT_Z     = 3'd5;

    localparam logic signed [AW-1:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [AW-1:0] ANG_FOUR_PI = 34'sd3373259426;
    localparam logic signed [AW-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [AW-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [AW-1:0] T_LIMIT     = 34'sd4294967295;

    localparam logic signed [31:0] ONE_VAL = 32'sd1 <<< VALUE_FRAC_BITS;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cmd_t;

    typedef logic [3:0][3:0][31:0] matrix_t;

    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] t [30];
        t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
              32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
              32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
              32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
              32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
              32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};
        return t[i];
    endfunction

    // round half up, then arithmetic shift right
    function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                       input int n);
        logic signed [PW-1:0] half;
        half = (n == 0) ? '0 : (PW'(1) <<< (n - 1));
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        if (v > PW'(64'sd2147483647))
            return 32'sh7FFFFFFF;
        else if (v < -PW'(64'sd2147483648))
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

/* sv/tmg_angle_reduce.sv */
// Two-stage reduction of a Q3.28 angle to a Q2.30 CORDIC input within +-pi/2.
module tmg_angle_reduce import tmg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cmd_t                 in_cmd,
    input  logic signed [31:0]   in_angle,
    output logic                 out_valid,
    output cmd_t                 out_cmd,
    output logic signed [AW-1:0] out_z,
    output logic                 out_flip
);
    logic                 v1_reg, v2_reg;
    cmd_t                 c1_reg, c2_reg;
    logic signed [AW-1:0] r1_reg, r1_next, z_reg, z_next;
    logic                 flip_reg, flip_next;
    logic signed [AW-1:0] a, r2;

    // floored modulo two pi
    always_comb begin
        a = AW'(in_angle);
        if (a >= ANG_TWO_PI)
            r1_next = a - ANG_TWO_PI;
        else if (a >= 0)
            r1_next = a;
        else if (a + ANG_TWO_PI >= 0)
            r1_next = a + ANG_TWO_PI;
        else
            r1_next = a + ANG_FOUR_PI;
    end

    always_comb begin
        r2 = (r1_reg > ANG_PI) ? r1_reg - ANG_TWO_PI : r1_reg;
        flip_next = 1'b0;
        z_next = r2;
        if (r2 > ANG_HALF_PI) begin
            z_next = r2 - ANG_PI;
            flip_next = 1'b1;
        end else if (r2 < -ANG_HALF_PI) begin
            z_next = r2 + ANG_PI;
            flip_next = 1'b1;
        end
        z_next = z_next <<< 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= in_cmd;
            r1_reg   <= r1_next;
            c2_reg   <= c1_reg;
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_cmd   = c2_reg;
    assign out_z     = z_reg;
    assign out_flip  = flip_reg;
endmodule

/* sv/tmg_cordic.sv */
// Pipelined rotation-mode CORDIC, one register stage per iteration.
module tmg_cordic import tmg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cmd_t                 in_cmd,
    input  logic signed [AW-1:0] in_z,
    input  logic                 in_flip,
    output logic                 out_valid,
    output cmd_t                 out_cmd,
    output logic signed [AW-1:0] out_c,
    output logic signed [AW-1:0] out_s,
    output logic                 out_flip
);
    // entry i holds the state after iteration i
    logic                 v_reg    [CORDIC_STAGES];
    cmd_t                 cmd_reg  [CORDIC_STAGES];
    logic                 flip_reg [CORDIC_STAGES];
    logic signed [AW-1:0] x_reg    [CORDIC_STAGES];
    logic signed [AW-1:0] y_reg    [CORDIC_STAGES];
    logic signed [AW-1:0] z_reg    [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic                 v_in, flip_in;
        cmd_t                 cmd_in;
        logic signed [AW-1:0] x_in, y_in, z_in;
        logic signed [AW-1:0] dx, dy, at, x_next, y_next, z_next;
        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign cmd_in  = in_cmd;
            assign flip_in = in_flip;
            assign x_in    = CORDIC_GAIN;
            assign y_in    = '0;
            assign z_in    = in_z;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign cmd_in  = cmd_reg[i-1];
            assign flip_in = flip_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
        end
        always_comb begin
            dx = y_in >>> i;
            dy = x_in >>> i;
            at = AW'(atan_q30(i));
            if (z_in >= 0) begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - at;
            end else begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + at;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_in;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cmd_reg[i]  <= cmd_in;
                flip_reg[i] <= flip_in;
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_cmd   = cmd_reg[CORDIC_STAGES-1];
    assign out_c     = x_reg[CORDIC_STAGES-1];
    assign out_s     = y_reg[CORDIC_STAGES-1];
    assign out_flip  = flip_reg[CORDIC_STAGES-1];
endmodule

/* sv/tmg_matrix.sv */
// Product, rounding and sum stages that build the 4x4 matrix from sine and cosine.
module tmg_matrix import tmg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cmd_t                 in_cmd,
    input  logic signed [AW-1:0] in_c,
    input  logic signed [AW-1:0] in_s,
    input  logic                 in_flip,
    output logic                 out_valid,
    output matrix_t              out_mat
);
    localparam int VSH = 30 - VALUE_FRAC_BITS;

    logic [4:0] v_reg;
    cmd_t       cmd_reg [4];

    // stage 0: sign fold, value conversion
    logic signed [AW-1:0] c0, s0;
    logic signed [PW-1:0] cv0_w, sv0_w;
    logic signed [AW-1:0] cv0_reg, sv0_reg, c10_reg, s0_reg;
    always_comb begin
        c0 = in_flip ? -in_c : in_c;
        s0 = in_flip ? -in_s : in_s;
        if (!(in_cmd.cmd == CMD_AXIS_ROT || in_cmd.cmd == CMD_ROT_X ||
              in_cmd.cmd == CMD_ROT_Y || in_cmd.cmd == CMD_ROT_Z)) begin
            c0 = ONE_Q30;
            s0 = '0;
        end
        cv0_w = rnd_shift(PW'(c0), VSH);
        sv0_w = rnd_shift(PW'(s0), VSH);
    end

    // stage 1 products
    logic signed [PW-1:0] pcx_reg, pcy_reg, pcz_reg, psx_reg, psy_reg, psz_reg;
    logic signed [AW-1:0] cv1_reg, sv1_reg;
    // stage 2 rounded
    logic signed [AW-1:0] tx_reg, ty_reg, tz_reg, cv2_reg, sv2_reg;
    logic signed [PW-1:0] qx_reg, qy_reg, qz_reg;
    // stage 3 second products
    logic signed [PW-1:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    logic signed [PW-1:0] qx3_reg, qy3_reg, qz3_reg;
    logic signed [AW-1:0] cv3_reg, sv3_reg;
    matrix_t              mat_reg, mat_next;

    function automatic logic signed [AW-1:0] clamp_t(input logic signed [PW-1:0] v);
        if (v > PW'(T_LIMIT))
            return T_LIMIT;
        else if (v < -PW'(T_LIMIT))
            return -T_LIMIT;
        else
            return v[AW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg[0] <= in_cmd;
            for (int i = 1; i < 4; i++)
                cmd_reg[i] <= cmd_reg[i-1];
            cv0_reg <= cv0_w[AW-1:0];
            sv0_reg <= sv0_w[AW-1:0];
            c10_reg <= ONE_Q30 - c0;
            s0_reg  <= s0;

            pcx_reg <= PW'(c10_reg) * PW'(cmd_reg[0].x);
            pcy_reg <= PW'(c10_reg) * PW'(cmd_reg[0].y);
            pcz_reg <= PW'(c10_reg) * PW'(cmd_reg[0].z);
            psx_reg <= PW'(s0_reg) * PW'(cmd_reg[0].x);
            psy_reg <= PW'(s0_reg) * PW'(cmd_reg[0].y);
            psz_reg <= PW'(s0_reg) * PW'(cmd_reg[0].z);
            cv1_reg <= cv0_reg;
            sv1_reg <= sv0_reg;

            tx_reg  <= clamp_t(rnd_shift(pcx_reg, 30));
            ty_reg  <= clamp_t(rnd_shift(pcy_reg, 30));
            tz_reg  <= clamp_t(rnd_shift(pcz_reg, 30));
            qx_reg  <= rnd_shift(psx_reg, 30);
            qy_reg  <= rnd_shift(psy_reg, 30);
            qz_reg  <= rnd_shift(psz_reg, 30);
            cv2_reg <= cv1_reg;
            sv2_reg <= sv1_reg;

            pxx_reg <= PW'(tx_reg) * PW'(cmd_reg[2].x);
            pyy_reg <= PW'(ty_reg) * PW'(cmd_reg[2].y);
            pzz_reg <= PW'(tz_reg) * PW'(cmd_reg[2].z);
            pxy_reg <= PW'(tx_reg) * PW'(cmd_reg[2].y);
            pxz_reg <= PW'(tx_reg) * PW'(cmd_reg[2].z);
            pyz_reg <= PW'(ty_reg) * PW'(cmd_reg[2].z);
            qx3_reg <= qx_reg;
            qy3_reg <= qy_reg;
            qz3_reg <= qz_reg;
            cv3_reg <= cv2_reg;
            sv3_reg <= sv2_reg;

            mat_reg <= mat_next;
        end
    end

    logic signed [PW-1:0] dxx, dyy, dzz, dxy, dxz, dyz, cvw, svw;
    always_comb begin
        dxx = rnd_shift(pxx_reg, VALUE_FRAC_BITS);
        dyy = rnd_shift(pyy_reg, VALUE_FRAC_BITS);
        dzz = rnd_shift(pzz_reg, VALUE_FRAC_BITS);
        dxy = rnd_shift(pxy_reg, VALUE_FRAC_BITS);
        dxz = rnd_shift(pxz_reg, VALUE_FRAC_BITS);
        dyz = rnd_shift(pyz_reg, VALUE_FRAC_BITS);
        cvw = PW'(cv3_reg);
        svw = PW'(sv3_reg);
        mat_next = '0;
        for (int r = 0; r < 4; r++)
            mat_next[r][r] = ONE_VAL;
        unique case (cmd_reg[3].cmd)
            CMD_TRANSLATE: begin
                mat_next[0][3] = cmd_reg[3].x;
                mat_next[1][3] = cmd_reg[3].y;
                mat_next[2][3] = cmd_reg[3].z;
            end
            CMD_SCALE: begin
                mat_next[0][0] = cmd_reg[3].x;
                mat_next[1][1] = cmd_reg[3].y;
                mat_next[2][2] = cmd_reg[3].z;
            end
            CMD_AXIS_ROT: begin
                mat_next[0][0] = sat32(cvw + dxx);
                mat_next[1][1] = sat32(cvw + dyy);
                mat_next[2][2] = sat32(cvw + dzz);
                mat_next[0][1] = sat32(dxy - qz3_reg);
                mat_next[1][0] = sat32(dxy + qz3_reg);
                mat_next[0][2] = sat32(dxz + qy3_reg);
                mat_next[2][0] = sat32(dxz - qy3_reg);
                mat_next[1][2] = sat32(dyz - qx3_reg);
                mat_next[2][1] = sat32(dyz + qx3_reg);
            end
            CMD_ROT_X: begin
                mat_next[1][1] = sat32(cvw);
                mat_next[2][2] = sat32(cvw);
                mat_next[1][2] = sat32(-svw);
                mat_next[2][1] = sat32(svw);
            end
            CMD_ROT_Y: begin
                mat_next[0][0] = sat32(cvw);
                mat_next[2][2] = sat32(cvw);
                mat_next[2][0] = sat32(-svw);
                mat_next[0][2] = sat32(svw);
            end
            CMD_ROT_Z: begin
                mat_next[0][0] = sat32(cvw);
                mat_next[1][1] = sat32(cvw);
                mat_next[0][1] = sat32(-svw);
                mat_next[1][0] = sat32(svw);
            end
            default: ;   // unknown command: identity
        endcase
    end

    assign out_valid = v_reg[4];
    assign out_mat   = mat_reg;
endmodule

/* sv/tmg_row_out.sv */
// Output buffer that holds one matrix and sends it as four row words.
module tmg_row_out import tmg_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  matrix_t       in_mat,
    output logic          take,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    logic       busy_reg;
    logic [1:0] row_reg;
    matrix_t    buf_reg;
    logic       done;

    assign done = busy_reg && m_tready && row_reg == 2'd3;
    assign take = in_valid && (!busy_reg || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (take) begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            busy_reg <= row_reg != 2'd3;
            row_reg  <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take)
            buf_reg <= in_mat;
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = row_reg;
    assign m_tlast  = row_reg == 2'd3;
    assign m_tdata  = {buf_reg[row_reg][3], buf_reg[row_reg][2],
                       buf_reg[row_reg][1], buf_reg[row_reg][0]};
endmodule

/* sv/transform_matrix_generator_top.sv */
// Transform matrix generator: one command word in, four 4x4 matrix row words out.
// A command passes the angle reduction, the CORDIC pipeline and the product stages;
// the output buffer then sends its matrix as four row words, row 0 first, with tlast
// on row 3. A new matrix is taken into the buffer only when it is empty or sends its
// last row word, so the four row words on the single result channel limit how often
// a command is taken, while the angle reduction, the CORDIC pipeline and the product
// stages keep several commands in flight. All stages advance together and hold when
// the output buffer cannot take the next matrix.
module transform_matrix_generator_top import tmg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // x_value, y_value, z_value, angle
    input  logic [2:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // entry_0, entry_1, entry_2, entry_3
    output logic [1:0]   m_tuser,   // row_index
    output logic         m_tlast    // last_row
);
    logic                 en, take;
    cmd_t                 in_cmd, ar_cmd, co_cmd;
    logic                 ar_valid, co_valid, mx_valid;
    logic signed [AW-1:0] ar_z, co_c, co_s;
    logic                 ar_flip, co_flip;
    matrix_t              mx_mat;

    assign en       = !mx_valid || take;
    assign s_tready = en;

    assign in_cmd.cmd = s_tuser;
    assign in_cmd.x   = s_tdata[31:0];
    assign in_cmd.y   = s_tdata[63:32];
    assign in_cmd.z   = s_tdata[95:64];

    tmg_angle_reduce u_reduce (
        .aclk, .aresetn, .en,
        .in_valid (s_tvalid), .in_cmd, .in_angle (s_tdata[127:96]),
        .out_valid (ar_valid), .out_cmd (ar_cmd), .out_z (ar_z), .out_flip (ar_flip)
    );

    tmg_cordic u_cordic (
        .aclk, .aresetn, .en,
        .in_valid (ar_valid), .in_cmd (ar_cmd), .in_z (ar_z), .in_flip (ar_flip),
        .out_valid (co_valid), .out_cmd (co_cmd), .out_c (co_c), .out_s (co_s),
        .out_flip (co_flip)
    );

    tmg_matrix u_matrix (
        .aclk, .aresetn, .en,
        .in_valid (co_valid), .in_cmd (co_cmd), .in_c (co_c), .in_s (co_s),
        .in_flip (co_flip), .out_valid (mx_valid), .out_mat (mx_mat)
    );

    tmg_row_out u_rows (
        .aclk, .aresetn,
        .in_valid (mx_valid), .in_mat (mx_mat), .take,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
endmodule

/* sv/tmg_checker.sv */
// Port-level checks on the row word stream, bound to the top level.
module tmg_port_checks (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("tlast does not match row 3");

    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 2'd1)
        else $error("matrix rows not sent in sequence");

    a_new_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tuser == 2'd0)
        else $error("matrix does not start at row 0");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled word changed");
endmodule

bind transform_matrix_generator_top tmg_port_checks u_tmg_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

/* test/tmg_checker.sv */
// Checker for the transform matrix generator: predicts each matrix and compares row words.
module tmg_checker import tmg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           rows_pending
);

    typedef struct {
        logic [1:0]  row;
        logic [31:0] e [4];
        logic        last;
    } row_word_t;

    row_word_t row_queue[$];

    localparam longint TWO_PI_L  = 64'sd1686629713;
    localparam longint PI_L      = 64'sd843314857;
    localparam longint HALF_PI_L = 64'sd421657428;
    localparam longint GAIN_L    = 64'sd652032874;
    localparam longint ONE30_L   = 64'sd1073741824;

    // floor shift with half-LSB rounding; 128-bit to hold 64x64 products
    function automatic logic signed [127:0] round_shr(logic signed [127:0] v, int n);
        if (n == 0) return v;
        return (v + (128'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [127:0] clip_t(logic signed [127:0] v);
        if (v > 128'sd4294967295) return 128'sd4294967295;
        if (v < -128'sd4294967295) return -128'sd4294967295;
        return v;
    endfunction

    function automatic logic [31:0] clip32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7FFFFFFF;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] prod_s(longint q, longint u);
        logic signed [127:0] p;
        p = 128'(q) * 128'(u);
        return round_shr(p, 30);
    endfunction

    function automatic logic signed [127:0] prod_c1(longint c1, longint u, longint w);
        logic signed [127:0] t;
        t = clip_t(prod_s(c1, u));
        return round_shr(t * 128'(w), VALUE_FRAC_BITS);
    endfunction

    task automatic sine_cosine(input longint ang, output longint s, output longint c);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = ang % TWO_PI_L;
        flip = 0;
        if (r < 0) r += TWO_PI_L;
        if (r > PI_L) r -= TWO_PI_L;
        if (r > HALF_PI_L) begin
            r -= PI_L;
            flip = 1;
        end else if (r < -HALF_PI_L) begin
            r += PI_L;
            flip = 1;
        end
        x = GAIN_L;
        y = 0;
        z = r * 4;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q30(i));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(atan_q30(i));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    task automatic predict_matrix(input logic [2:0] cmd, input logic [127:0] d);
        logic signed [127:0] m [4][4];
        longint x, y, z, ang, s, c, c1;
        logic signed [127:0] sv, cv;
        row_word_t w;
        x = longint'($signed(d[31:0]));
        y = longint'($signed(d[63:32]));
        z = longint'($signed(d[95:64]));
        ang = longint'($signed(d[127:96]));
        s = 0;
        c = ONE30_L;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
                m[r][k] = (r == k) ? (128'sd1 <<< VALUE_FRAC_BITS) : 128'sd0;
        if (cmd inside {CMD_AXIS_ROT, CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z})
            sine_cosine(ang, s, c);
        sv = round_shr(128'(s), 30 - VALUE_FRAC_BITS);
        cv = round_shr(128'(c), 30 - VALUE_FRAC_BITS);
        c1 = ONE30_L - c;
        case (cmd)
            CMD_TRANSLATE: begin
                m[0][3] = x; m[1][3] = y; m[2][3] = z;
            end
            CMD_SCALE: begin
                m[0][0] = x; m[1][1] = y; m[2][2] = z;
            end
            CMD_AXIS_ROT: begin
                m[0][0] = cv + prod_c1(c1, x, x);
                m[1][1] = cv + prod_c1(c1, y, y);
                m[2][2] = cv + prod_c1(c1, z, z);
                m[0][1] = prod_c1(c1, x, y) - prod_s(s, z);
                m[1][0] = prod_c1(c1, x, y) + prod_s(s, z);
                m[0][2] = prod_c1(c1, x, z) + prod_s(s, y);
                m[2][0] = prod_c1(c1, x, z) - prod_s(s, y);
                m[1][2] = prod_c1(c1, y, z) - prod_s(s, x);
                m[2][1] = prod_c1(c1, y, z) + prod_s(s, x);
            end
            CMD_ROT_X: begin
                m[1][1] = cv; m[2][2] = cv; m[1][2] = -sv; m[2][1] = sv;
            end
            CMD_ROT_Y: begin
                m[0][0] = cv; m[2][2] = cv; m[2][0] = -sv; m[0][2] = sv;
            end
            CMD_ROT_Z: begin
                m[0][0] = cv; m[1][1] = cv; m[0][1] = -sv; m[1][0] = sv;
            end
            default: ;
        endcase
        for (int r = 0; r < 4; r++) begin
            w.row = r[1:0];
            for (int k = 0; k < 4; k++) w.e[k] = clip32(m[r][k]);
            w.last = (r == 3);
            row_queue.push_back(w);
        end
    endtask

    initial begin
        fail_count = 0;
        rows_pending = 0;
    end

    always @(posedge aclk) begin
        row_word_t exp_w;
        bit bad;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (row_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected row word: row %0d data %h", m_tuser, m_tdata);
                end else begin
                    exp_w = row_queue.pop_front();
                    bad = (m_tuser != exp_w.row) || (m_tlast != exp_w.last);
                    for (int k = 0; k < 4; k++)
                        if (m_tdata[32*k +: 32] != exp_w.e[k]) bad = 1;
                    if (bad) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"row mismatch: exp row %0d last %0d %h %h %h %h, ",
                                      "got row %0d last %0d %h"},
                                     exp_w.row, exp_w.last, exp_w.e[3], exp_w.e[2],
                                     exp_w.e[1], exp_w.e[0], m_tuser, m_tlast, m_tdata);
                    end
                end
            end
            // predict after popping so a same-cycle command never aliases
            if (s_tvalid && s_tready)
                predict_matrix(s_tuser, s_tdata);
            rows_pending <= row_queue.size();
        end
    end

endmodule

/* test/testbench.sv */
// Testbench top for the transform matrix generator: stimulus, stalls and verdict.
module testbench import tmg_pkg::*; ();

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           rows_pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    transform_matrix_generator_top dut (.*);

    tmg_checker chk (.*);

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return 32'hFFFF0000;
            4: return $urandom_range(131072) - 65536;  // near-unit axis parts
            5: return 32'h0000B505;                    // about 1/sqrt(2)
            default: return $urandom;
        endcase
    endfunction

    // one command word; holds valid until the handshake
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {ang, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [2:0] cmd;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            send_cmd(cmd, pick_value(), pick_value(), pick_value(), $urandom);
        end
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (rows_pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: every command, field extremes, angle wrap, unknown codes
        send_cmd(CMD_TRANSLATE, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h0);
        send_cmd(CMD_SCALE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_cmd(CMD_ROT_X, 0, 0, 0, 32'h0);
        send_cmd(CMD_ROT_X, 0, 0, 0, 32'h7FFFFFFF);
        send_cmd(CMD_ROT_Y, 0, 0, 0, 32'h80000000);
        send_cmd(CMD_ROT_Z, 0, 0, 0, 32'd421657428);
        send_cmd(CMD_ROT_Z, 0, 0, 0, -32'd421657428);
        send_cmd(CMD_ROT_Y, 0, 0, 0, 32'd843314857);
        send_cmd(CMD_ROT_X, 0, 0, 0, -32'd843314857);
        send_cmd(CMD_ROT_Z, 0, 0, 0, 32'd1686629713);
        send_cmd(CMD_AXIS_ROT, 32'h00010000, 0, 0, 32'd300000000);
        send_cmd(CMD_AXIS_ROT, 0, 32'h0000B505, 32'h0000B505, -32'd500000000);
        send_cmd(CMD_AXIS_ROT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd843314857);
        send_cmd(CMD_AXIS_ROT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_cmd(3'd6, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'h55555555);
        send_cmd(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hAAAAAAAA);
        s_tvalid <= 0;
        drain();  // sender holds off until every row has come back
        send_random(30);
        send_idle_pct = 65;
        send_random(28);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        send_random(28);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        send_random(28);
        drain();
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
